### hw/rtl/c3zp_pkg.sv
`timescale 1ns / 1ps

package c3zp_pkg;

    // Default frame limits handed to the top level
    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int DEFAULT_MAX_HEIGHT = 1024;

    // Datapath widths
    localparam int PIX_W     = 8;
    localparam int COEF_W    = 8;
    localparam int PROD_W    = 17;
    localparam int SUM_W     = 21;
    localparam int RES_W     = 16;
    localparam int FRAC_BITS = 4;
    localparam int TAPS      = 9;
    localparam int KROWS     = 3;

    // Configuration port
    localparam int CFG_DATA_W = 24;
    localparam int CFG_ADDR_W = 3;
    localparam int DIM_CFG_W  = 11;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KERNEL_TOP   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_KERNEL_MID   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_KERNEL_BOT   = 3'd4;

    // Register reset values
    localparam int                    RESET_FRAME_WIDTH  = 640;
    localparam int                    RESET_FRAME_HEIGHT = 480;
    localparam logic [CFG_DATA_W-1:0] KERNEL_RESET       = 24'h181818;

    // Item kind on the input tuser
    localparam logic OP_PIXEL = 1'b0;

    // Border masks of one result: which neighbour rows and columns lie inside
    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } tap_mask_t;

    // One 3x3 window ready for the multiply stage, tap index is row*3+column
    typedef struct packed {
        logic                         last;
        tap_mask_t                    mask;
        logic [TAPS-1:0][PIX_W-1:0]   pix;
    } win_item_t;

    typedef logic [KROWS-1:0][CFG_DATA_W-1:0] kernel_t;

endpackage

### hw/rtl/c3zp_ram.sv
`timescale 1ns / 1ps

module c3zp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, holds between reads, returns old data on collision
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/c3zp_window.sv
`timescale 1ns / 1ps

module c3zp_window #(
    parameter int MAX_WIDTH  = c3zp_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = c3zp_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               restart,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]     frame_width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]    frame_height,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               in_op,
    input  logic [c3zp_pkg::PIX_W-1:0]         in_pixel,
    output logic                               out_valid,
    input  logic                               out_ready,
    output c3zp_pkg::win_item_t                out_item
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int PW    = c3zp_pkg::PIX_W;

    // Stream position
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // Input stage
    logic                  a_valid_reg, a_valid_next;
    logic                  a_emit_reg;
    logic                  a_last_reg;
    c3zp_pkg::tap_mask_t   a_mask_reg;
    logic [PW-1:0]         a_pix_reg;
    logic [COL_W-1:0]      a_col_reg;

    // Window stage
    logic                                       b_valid_reg, b_valid_next;
    logic                                       b_last_reg;
    c3zp_pkg::tap_mask_t                        b_mask_reg;
    logic [c3zp_pkg::TAPS-1:0][PW-1:0]          win_reg;

    logic                accept;
    logic                a_move;
    logic                b_ready;
    logic [31:0]         col32, row32, w32, h32;
    logic                col_zero;
    logic [PW-1:0]       pix_v;
    logic                emit;
    logic                last;
    c3zp_pkg::tap_mask_t mask;
    logic [PW-1:0]       lsa_rdata, lsb_rdata;

    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || b_ready;
    assign accept   = in_valid && in_ready;
    assign a_move   = a_valid_reg && b_ready;

    assign col32    = 32'(col_reg);
    assign row32    = 32'(row_reg);
    assign w32      = 32'(frame_width);
    assign h32      = 32'(frame_height);
    assign col_zero = (col_reg == '0);

    // Decode the incoming position: pixel value, result center and borders
    always_comb begin
        pix_v = '0;
        if (in_op == c3zp_pkg::OP_PIXEL && row32 < h32) begin
            pix_v = in_pixel;
        end
        if (!col_zero) begin
            emit          = (row32 >= 32'd1) && (row32 <= h32);
            last          = 1'b0;
            mask.top_ok   = (row32 >= 32'd2);
            mask.bot_ok   = (row32 < h32);
            mask.left_ok  = (col32 >= 32'd2);
            mask.right_ok = 1'b1;
        end else begin
            emit          = (row32 >= 32'd2) && (row32 <= h32 + 32'd1);
            last          = (row32 == h32 + 32'd1);
            mask.top_ok   = (row32 >= 32'd3);
            mask.bot_ok   = (row32 <= h32);
            mask.left_ok  = 1'b1;
            mask.right_ok = 1'b0;
        end
    end

    // Advance the position on every accepted item
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (last) begin
                col_next = '0;
                row_next = '0;
            end else if (col32 + 32'd1 >= w32) begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        if (accept) begin
            a_valid_next = 1'b1;
        end else if (a_move) begin
            a_valid_next = 1'b0;
        end
    end

    // Drop items that give no result at the window stage
    always_comb begin
        b_valid_next = b_valid_reg;
        if (a_move) begin
            b_valid_next = a_emit_reg;
        end else if (out_ready) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Capture the decoded item
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_emit_reg <= emit;
            a_last_reg <= last;
            a_mask_reg <= mask;
            a_pix_reg  <= pix_v;
            a_col_reg  <= col_reg;
        end
    end

    // Shift the window left and load the new column from the line stores
    always_ff @(posedge aclk) begin
        if (a_move) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r*3]     <= win_reg[r*3 + 1];
                win_reg[r*3 + 1] <= win_reg[r*3 + 2];
            end
            win_reg[2]  <= lsb_rdata;
            win_reg[5]  <= lsa_rdata;
            win_reg[8]  <= a_pix_reg;
            b_last_reg  <= a_last_reg;
            b_mask_reg  <= a_mask_reg;
        end
    end

    // Line store holding the previous row
    c3zp_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .aclk  (aclk),
        .we    (a_move),
        .waddr (a_col_reg),
        .wdata (a_pix_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (lsa_rdata)
    );

    // Line store holding the row before that
    c3zp_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .aclk  (aclk),
        .we    (a_move),
        .waddr (a_col_reg),
        .wdata (lsa_rdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (lsb_rdata)
    );

    assign out_valid     = b_valid_reg;
    assign out_item.last = b_last_reg;
    assign out_item.mask = b_mask_reg;
    assign out_item.pix  = win_reg;

endmodule

### hw/rtl/c3zp_mac.sv
`timescale 1ns / 1ps

module c3zp_mac (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  c3zp_pkg::win_item_t               in_item,
    input  c3zp_pkg::kernel_t                 kernel,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [c3zp_pkg::RES_W-1:0]        m_tdata,
    output logic                              m_tlast
);

    localparam int PROD_W = c3zp_pkg::PROD_W;
    localparam int SUM_W  = c3zp_pkg::SUM_W;
    localparam int RES_W  = c3zp_pkg::RES_W;
    localparam int FRAC   = c3zp_pkg::FRAC_BITS;
    localparam int CW     = c3zp_pkg::COEF_W;
    localparam int TAPS   = c3zp_pkg::TAPS;

    // Product stage
    logic                     c_valid_reg, c_valid_next;
    logic                     c_last_reg;
    logic signed [PROD_W-1:0] c_prod_reg  [TAPS];
    logic signed [PROD_W-1:0] c_prod_next [TAPS];

    // Output register
    logic                     m_valid_reg, m_valid_next;
    logic [RES_W-1:0]         m_data_reg, m_data_next;
    logic                     m_last_reg;

    logic                     d_ready;
    logic                     c_load;
    logic                     d_load;
    logic [2:0]               row_ok;
    logic [2:0]               col_ok;
    logic signed [SUM_W-1:0]  sum;

    assign d_ready  = !m_valid_reg || m_tready;
    assign in_ready = !c_valid_reg || d_ready;
    assign c_load   = in_valid && in_ready;
    assign d_load   = c_valid_reg && d_ready;

    assign row_ok = {in_item.mask.bot_ok, 1'b1, in_item.mask.top_ok};
    assign col_ok = {in_item.mask.right_ok, 1'b1, in_item.mask.left_ok};

    // Nine masked taps: unsigned pixel times signed coefficient
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (row_ok[r] && col_ok[c]) begin
                    c_prod_next[r*3 + c] =
                        PROD_W'($signed({1'b0, in_item.pix[r*3 + c]}))
                        * PROD_W'($signed(kernel[r][CW*c +: CW]));
                end else begin
                    c_prod_next[r*3 + c] = '0;
                end
            end
        end
    end

    // Add the taps and floor-shift out the fraction
    always_comb begin
        sum = '0;
        for (int i = 0; i < TAPS; i++) begin
            sum = sum + SUM_W'(c_prod_reg[i]);
        end
        m_data_next = sum[RES_W+FRAC-1:FRAC];
    end

    always_comb begin
        c_valid_next = c_valid_reg;
        if (c_load) begin
            c_valid_next = 1'b1;
        end else if (d_ready) begin
            c_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (d_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= c_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_load) begin
            c_prod_reg <= c_prod_next;
            c_last_reg <= in_item.last;
        end
    end

    // Hold the result while the receiver stalls
    always_ff @(posedge aclk) begin
        if (d_load) begin
            m_data_reg <= m_data_next;
            m_last_reg <= c_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

### hw/rtl/conv3x3_zero_pad_stream_unit.sv
`timescale 1ns / 1ps

// 3x3 convolution with zero padding over a raster stream of 8-bit pixels.
// Input channel s_*: one item per pixel in raster order; s_tuser = 0 for a
// pixel, 1 for a flush item. After the last pixel of a frame, send
// frame_width+1 flush items to drain the remaining results.
// Result channel m_*: one item per frame pixel, m_tdata is the signed sum
// floor-shifted by four, m_tlast marks the frame's final pixel.
// Configuration: write cfg_wr_data to register cfg_addr while idle. Index 0
// frame width, 1 frame height (both clamped to 3..MAX), 2..4 kernel rows
// (top, middle, bottom; three signed Q3.4 bytes, left tap lowest). Writing
// width or height restarts the frame.
// Throughput: one item per cycle while m_tready keeps the output free. A
// result passes the input stage, the window stage, the product register
// and the output register after the item that completes its window is
// accepted; in stream terms results lag by one row plus one pixel.
// Reset clears the pipeline, the position and the registers to their
// defaults (640x480, every tap 1.5); line stores are not cleared.
// When m_tready is low the result holds and up to three more items that
// give results are taken into empty stages before s_tready drops.
module conv3x3_zero_pad_stream_unit #(
    parameter int MAX_WIDTH  = c3zp_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = c3zp_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [c3zp_pkg::PIX_W-1:0]         s_tdata,     // [7:0] pixel
    input  logic                               s_tuser,     // [0] op
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [c3zp_pkg::RES_W-1:0]         m_tdata,     // [15:0] filtered
    output logic                               m_tlast,
    // configuration writes
    input  logic                               cfg_wr_en,
    input  logic [c3zp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [c3zp_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    localparam int WD_W = $clog2(MAX_WIDTH + 1);
    localparam int HT_W = $clog2(MAX_HEIGHT + 1);
    localparam int RESET_W_EFF = (c3zp_pkg::RESET_FRAME_WIDTH > MAX_WIDTH) ?
                                 MAX_WIDTH : c3zp_pkg::RESET_FRAME_WIDTH;
    localparam int RESET_H_EFF = (c3zp_pkg::RESET_FRAME_HEIGHT > MAX_HEIGHT) ?
                                 MAX_HEIGHT : c3zp_pkg::RESET_FRAME_HEIGHT;

    logic [WD_W-1:0]       width_reg, width_next;
    logic [HT_W-1:0]       height_reg, height_next;
    c3zp_pkg::kernel_t     kernel_reg, kernel_next;
    logic [31:0]           wr_dim;
    logic                  restart;
    logic                  win_valid;
    logic                  win_ready;
    c3zp_pkg::win_item_t   win_item;

    assign wr_dim = 32'(cfg_wr_data[c3zp_pkg::DIM_CFG_W-1:0]);

    // Decode configuration writes; clamp dimensions on the way in
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        kernel_next = kernel_reg;
        restart     = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                c3zp_pkg::REG_FRAME_WIDTH: begin
                    restart = 1'b1;
                    if (wr_dim < 32'd3) begin
                        width_next = WD_W'(3);
                    end else if (wr_dim > 32'(MAX_WIDTH)) begin
                        width_next = WD_W'(MAX_WIDTH);
                    end else begin
                        width_next = WD_W'(wr_dim);
                    end
                end
                c3zp_pkg::REG_FRAME_HEIGHT: begin
                    restart = 1'b1;
                    if (wr_dim < 32'd3) begin
                        height_next = HT_W'(3);
                    end else if (wr_dim > 32'(MAX_HEIGHT)) begin
                        height_next = HT_W'(MAX_HEIGHT);
                    end else begin
                        height_next = HT_W'(wr_dim);
                    end
                end
                c3zp_pkg::REG_KERNEL_TOP: kernel_next[0] = cfg_wr_data;
                c3zp_pkg::REG_KERNEL_MID: kernel_next[1] = cfg_wr_data;
                c3zp_pkg::REG_KERNEL_BOT: kernel_next[2] = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WD_W'(RESET_W_EFF);
            height_reg <= HT_W'(RESET_H_EFF);
            kernel_reg <= {c3zp_pkg::KROWS{c3zp_pkg::KERNEL_RESET}};
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            kernel_reg <= kernel_next;
        end
    end

    // Position tracking, line stores and 3x3 window
    c3zp_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .restart      (restart),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_op        (s_tuser),
        .in_pixel     (s_tdata),
        .out_valid    (win_valid),
        .out_ready    (win_ready),
        .out_item     (win_item)
    );

    // Multiply, add and output register
    c3zp_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (win_valid),
        .in_ready (win_ready),
        .in_item  (win_item),
        .kernel   (kernel_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### hw/rtl/c3zp_checker.sv
`timescale 1ns / 1ps

module c3zp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [c3zp_pkg::RES_W-1:0]    m_tdata,
    input logic                          m_tlast
);

    logic m_accept;

    assign m_accept = m_tvalid && m_tready;

    // A stalled result holds its payload
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // With the output free the input side must take items
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled although output is free");

    // A frame has at least nine results, so frame ends never follow each other
    a_no_double_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_accept && m_tlast |=> !(m_tvalid && m_tlast))
        else $error("two frame ends in a row");

    // A stalled input item stays offered until it is taken
    a_valid_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid)
        else $error("input item withdrawn while stalled");

endmodule

bind conv3x3_zero_pad_stream_unit c3zp_checker u_c3zp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### bench/conv3x3_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, keeps its own image of the
// line stores and the 3x3 window, and checks every result item in order.
module conv3x3_result_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [c3zp_pkg::PIX_W-1:0]         s_tdata,     // [7:0] pixel
    input  logic                               s_tuser,     // [0] op
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [c3zp_pkg::RES_W-1:0]         m_tdata,     // [15:0] filtered
    input  logic                               m_tlast,
    input  logic                               cfg_wr_en,
    input  logic [c3zp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [c3zp_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    output int                                 mismatch_count,
    output int                                 filtered_pending
);
    import c3zp_pkg::*;

    localparam int unsigned LINE_DEPTH = DEFAULT_MAX_WIDTH;
    localparam int unsigned ROW_LIMIT  = DEFAULT_MAX_HEIGHT;

    typedef struct packed {
        logic signed [RES_W-1:0] filtered;
        logic                    frame_last;
    } filtered_t;

    filtered_t              filtered_fifo[$];
    logic [DIM_CFG_W-1:0]   width_code;
    logic [DIM_CFG_W-1:0]   height_code;
    kernel_t                kernel_rows;
    logic [PIX_W-1:0]       row_above [LINE_DEPTH];
    logic [PIX_W-1:0]       row_above2 [LINE_DEPTH];
    logic [PIX_W-1:0]       win [3][3];
    int unsigned            col_pos;
    int unsigned            row_pos;

    function automatic int unsigned used_dim(input logic [DIM_CFG_W-1:0] code,
                                             input int unsigned hi);
        if (code < 3) return 3;
        if (code > hi) return hi;
        return 32'(code);
    endfunction

    // Drop the frame in progress: position and window back to zero
    task automatic restart_frame();
        col_pos = 0;
        row_pos = 0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                win[r][c] = '0;
            end
        end
    endtask

    task automatic apply_write(input logic [CFG_ADDR_W-1:0] addr,
                               input logic [CFG_DATA_W-1:0] data);
        case (addr)
            REG_FRAME_WIDTH: begin
                width_code = data[DIM_CFG_W-1:0];
                restart_frame();
            end
            REG_FRAME_HEIGHT: begin
                height_code = data[DIM_CFG_W-1:0];
                restart_frame();
            end
            REG_KERNEL_TOP: kernel_rows[0] = data;
            REG_KERNEL_MID: kernel_rows[1] = data;
            REG_KERNEL_BOT: kernel_rows[2] = data;
            default: ;
        endcase
    endtask

    // Shift one item into the window and queue the result it completes, if any
    task automatic convolve_item(input logic op, input logic [PIX_W-1:0] pix);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned cr;
        int unsigned cc;
        logic [PIX_W-1:0] v;
        logic emit;
        logic last;
        bit [2:0] row_in;
        bit [2:0] col_in;
        int sum;
        filtered_t res;

        w = used_dim(width_code, LINE_DEPTH);
        h = used_dim(height_code, ROW_LIMIT);
        col = (col_pos >= w) ? w - 1 : col_pos;
        // Flushes in the pixel phase and anything in the drain phase become zero
        v = (op == OP_PIXEL && row_pos < h) ? pix : '0;

        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = row_above2[col];
        win[1][2] = row_above[col];
        win[2][2] = v;
        row_above2[col] = row_above[col];
        row_above[col] = v;

        emit = 1'b0;
        last = 1'b0;
        cr = 0;
        cc = 0;
        if (col >= 1) begin
            if (row_pos >= 1 && row_pos - 1 < h) begin
                emit = 1'b1;
                cr = row_pos - 1;
                cc = col - 1;
            end
        end else if (row_pos >= 2 && row_pos - 2 < h) begin
            // Column zero closes the right edge of the row above
            emit = 1'b1;
            cr = row_pos - 2;
            cc = w - 1;
            last = (row_pos == h + 1);
        end

        if (last) begin
            col_pos = 0;
            row_pos = 0;
        end else begin
            col_pos = col + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
        end

        if (emit) begin
            row_in = {cr + 1 < h, 1'b1, cr > 0};
            col_in = {cc + 1 < w, 1'b1, cc > 0};
            sum = 0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (row_in[r] && col_in[c]) begin
                        sum += int'(win[r][c]) * int'($signed(kernel_rows[r][8*c +: 8]));
                    end
                end
            end
            // Arithmetic shift floors toward minus infinity
            sum = sum >>> FRAC_BITS;
            res.filtered = sum[RES_W-1:0];
            res.frame_last = last;
            filtered_fifo.push_back(res);
        end
    endtask

    // Sample both channels and the register port at every rising edge
    always @(posedge aclk) begin : watch
        filtered_t got;
        filtered_t want;
        if (!aresetn) begin
            filtered_fifo.delete();
            width_code = DIM_CFG_W'(RESET_FRAME_WIDTH);
            height_code = DIM_CFG_W'(RESET_FRAME_HEIGHT);
            kernel_rows = {KROWS{KERNEL_RESET}};
            for (int i = 0; i < LINE_DEPTH; i++) begin
                row_above[i] = '0;
                row_above2[i] = '0;
            end
            restart_frame();
            mismatch_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.filtered = m_tdata;
                got.frame_last = m_tlast;
                if (filtered_fifo.size() == 0) begin
                    $display("%0t: result with none expected: expected none, got %0d last %0b",
                             $time, got.filtered, got.frame_last);
                    mismatch_count++;
                end else begin
                    want = filtered_fifo.pop_front();
                    if (got.filtered !== want.filtered) begin
                        $display("%0t: filtered mismatch: expected %0d, got %0d",
                                 $time, want.filtered, got.filtered);
                        mismatch_count++;
                    end
                    if (got.frame_last !== want.frame_last) begin
                        $display("%0t: frame_last mismatch: expected %0b, got %0b",
                                 $time, want.frame_last, got.frame_last);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                apply_write(cfg_addr, cfg_wr_data);
            end
            if (s_tvalid && s_tready) begin
                convolve_item(s_tuser, s_tdata);
            end
        end
        filtered_pending = filtered_fifo.size();
    end

endmodule

### bench/conv3x3_zero_pad_stream_unit_test.sv
`timescale 1ns / 1ps

module conv3x3_zero_pad_stream_unit_test;
    import c3zp_pkg::*;

    localparam logic OP_FLUSH      = 1'b1;
    localparam int   QUIET_LIMIT   = 2000;
    localparam int   SETTLE_CYCLES = 10;
    localparam int   TAIL_CYCLES   = 20;
    localparam int   RANDOM_ITEMS  = 650;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata     = '0;
    logic                  s_tuser     = OP_PIXEL;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [RES_W-1:0]      m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    int   mismatch_count;
    int   filtered_pending;
    int   send_gap_max   = 15;
    int   recv_stall_max = 15;
    int   recv_stall     = 0;
    logic m_took         = 1'b0;
    int   quiet_cycles   = 0;
    int   items_sent     = 0;

    conv3x3_zero_pad_stream_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    conv3x3_result_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wr_data      (cfg_wr_data),
        .mismatch_count   (mismatch_count),
        .filtered_pending (filtered_pending)
    );

    always #5 aclk = ~aclk;

    // Stall the result side at random after each taken result
    always @(posedge aclk) begin
        m_took <= m_tvalid && m_tready;
    end

    always @(negedge aclk) begin
        if (m_took) begin
            recv_stall = $urandom_range(0, recv_stall_max);
        end
        if (recv_stall > 0) begin
            m_tready <= 1'b0;
            recv_stall--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic op, input logic [PIX_W-1:0] pix);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        s_tuser <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Hold the input until every queued result is out, then let the pipe empty
    task automatic wait_for_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (filtered_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] wcode, hcode,
                             input logic [CFG_DATA_W-1:0] ktop, kmid, kbot);
        wait_for_idle();
        write_reg(REG_FRAME_WIDTH, wcode);
        write_reg(REG_FRAME_HEIGHT, hcode);
        write_reg(REG_KERNEL_TOP, ktop);
        write_reg(REG_KERNEL_MID, kmid);
        write_reg(REG_KERNEL_BOT, kbot);
    endtask

    function automatic int unsigned dim_used(input logic [CFG_DATA_W-1:0] code,
                                             input int unsigned hi);
        int unsigned v;
        v = 32'(code[DIM_CFG_W-1:0]);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    // Mostly small frames, sometimes below the clamp, sometimes junk upper bits
    function automatic logic [CFG_DATA_W-1:0] pick_dim_code();
        logic [CFG_DATA_W-1:0] code;
        code = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                           : CFG_DATA_W'($urandom_range(3, 10));
        if ($urandom_range(0, 3) == 0) begin
            code[CFG_DATA_W-1:DIM_CFG_W] = (CFG_DATA_W - DIM_CFG_W)'($urandom);
        end
        return code;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_kernel();
        case ($urandom_range(0, 7))
            0:       return 24'h7F7F7F;
            1:       return 24'h808080;
            2:       return 24'hFFFFFF;
            3:       return 24'h000000;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input int unsigned style);
        case (style)
            2:       return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            3:       return PIX_W'($urandom_range(0, 15));
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // One frame in raster order and its drain; noisy mixes in stray flushes
    // among the pixels and stray pixels among the flushes
    task automatic send_frame(input int unsigned w, h, drain_n, input bit noisy);
        int unsigned style;
        logic op;
        style = $urandom_range(0, 3);
        for (int unsigned i = 0; i < w * h; i++) begin
            op = (noisy && $urandom_range(0, 9) == 0) ? OP_FLUSH : OP_PIXEL;
            send_item(op, pick_pixel(style));
        end
        for (int unsigned i = 0; i < drain_n; i++) begin
            op = (noisy && $urandom_range(0, 4) == 0) ? OP_PIXEL : OP_FLUSH;
            send_item(op, PIX_W'($urandom));
        end
    endtask

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] wcode;
        logic [CFG_DATA_W-1:0] hcode;
        int unsigned w;
        int unsigned h;
        int unsigned nframes;
        int phase;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Smallest frame, reset kernel (every tap 1.5), brightest pixels
        wait_for_idle();
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
        for (int i = 0; i < 9; i++) send_item(OP_PIXEL, 8'hFF);
        for (int i = 0; i < 4; i++) send_item(OP_FLUSH, 8'hA5);

        // Most negative taps; a flush as the center pixel, a pixel in the drain
        configure(CFG_DATA_W'(3), CFG_DATA_W'(3), 24'h808080, 24'h808080, 24'h808080);
        for (int i = 0; i < 9; i++) send_item((i == 4) ? OP_FLUSH : OP_PIXEL, 8'hFF);
        for (int i = 0; i < 3; i++) send_item(OP_FLUSH, 8'hFF);
        send_item(OP_PIXEL, 8'hFF);

        // Random phases: new settings, a few frames, sometimes a broken tail
        phase = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            wcode = pick_dim_code();
            hcode = pick_dim_code();
            configure(wcode, hcode, pick_kernel(), pick_kernel(), pick_kernel());
            w = dim_used(wcode, DEFAULT_MAX_WIDTH);
            h = dim_used(hcode, DEFAULT_MAX_HEIGHT);
            case ($urandom_range(0, 3))
                0: begin send_gap_max = 15; recv_stall_max = 15; end
                1: begin send_gap_max = 0;  recv_stall_max = 0;  end
                2: begin send_gap_max = 0;  recv_stall_max = 15; end
                default: begin send_gap_max = 15; recv_stall_max = 0; end
            endcase
            nframes = $urandom_range(1, 3);
            for (int unsigned f = 0; f < nframes; f++) begin
                send_frame(w, h, w + 1, $urandom_range(0, 3) == 0);
                if (phase == 0 || $urandom_range(0, 4) == 0) begin
                    wait_for_idle();
                end
            end
            case ($urandom_range(0, 5))
                // abandon a partial frame at the next register write
                0: repeat ($urandom_range(1, w * h)) send_item(OP_PIXEL, PIX_W'($urandom));
                // cut the drain short so the next frame starts inside it
                1: begin
                    send_frame(w, h, $urandom_range(0, w), 1'b0);
                    send_frame(w, h, w + 1, 1'b0);
                end
                default: ;
            endcase
            phase++;
        end

        wait_for_idle();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
